// ===== hdl/assembly_source_tokenizer_unit_defines.svh =====
// Assertion macros for the tokenizer's checker file.
// Stands alone: no package or module is needed to expand these macros.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// General property, checked only while reset is released.
`define AST_ASSERT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("tokenizer check failed");

// Same-cycle implication, checked only while reset is released.
`define AST_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tokenizer implication failed");

`endif

// ===== hdl/ast_pkg.sv =====
// Shared types, constants and byte classifiers for the source tokenizer.
// No dependencies; every tokenizer module, the checker and two channel interfaces import it.
`default_nettype none

package ast_pkg;

	localparam int ROW_BITS_DEF    = 24;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 32;
	localparam int QUEUE_DEPTH     = 4;
	// kind, value byte, has-byte flag and last flag of one token item
	localparam int ITEM_FIXED_BITS = 3 + 8 + 1 + 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_START_ROW    = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_COLUMN = CFG_INDEX_BITS'(1);

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_APOSTROPHE = 8'h27;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_LOWER_B    = 8'h62;
	localparam logic [7:0] CH_LOWER_N    = 8'h6E;
	localparam logic [7:0] CH_LOWER_T    = 8'h74;
	localparam logic [7:0] CH_LOWER_X    = 8'h78;

	typedef enum logic [2:0] {
		KIND_IDENT = 3'd0,
		KIND_INT   = 3'd1,
		KIND_STR   = 3'd2,
		KIND_CHR   = 3'd3,
		KIND_COLON = 3'd4,
		KIND_EOF   = 3'd5
	} token_kind_t;

	typedef enum logic [3:0] {
		LEX_IDLE     = 4'd0,
		LEX_IDENT    = 4'd1,
		LEX_NUM      = 4'd2,
		LEX_STR      = 4'd3,
		LEX_STR_ESC  = 4'd4,
		LEX_CHR      = 4'd5,
		LEX_CHR_ESC  = 4'd6,
		LEX_CHR_SKIP = 4'd7,
		LEX_COMMENT  = 4'd8,
		LEX_HALT     = 4'd9
	} lex_mode_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} queue_status_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic [7:0] escape_value(input logic [7:0] b);
		logic [7:0] v;
		v = CH_NUL;
		if (b == CH_LOWER_N) begin
			v = CH_NEWLINE;
		end else if (b == CH_LOWER_T) begin
			v = CH_TAB;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ast_channels_if.sv =====
// Handshake channels of the tokenizer: source bytes, token items, register writes.
// Depends on ast_pkg for widths and the token kind type.
`default_nettype none

interface ast_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface ast_token_if
	import ast_pkg::*;
	#(
	parameter int ROW_BITS    = ROW_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
	);
	logic                   valid;
	logic                   ready;
	token_kind_t            token_kind;
	logic [7:0]             value_byte;
	logic                   has_byte;
	logic                   token_last;
	logic [ROW_BITS-1:0]    token_row;
	logic [COLUMN_BITS-1:0] token_column;

	modport source (output valid, output token_kind, output value_byte, output has_byte,
		output token_last, output token_row, output token_column, input ready);
	modport sink (input valid, input token_kind, input value_byte, input has_byte,
		input token_last, input token_row, input token_column, output ready);
endinterface

interface ast_cfg_if
	import ast_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/assembly_source_tokenizer_unit.sv =====
// Top level of the assembly source tokenizer: front end, record queue, back end.
// Depends on ast_pkg, the channel interfaces, ast_front, ast_queue and ast_back.
//
//   Channel     Direction  Transaction carries
//   cfg         in         register index, write data (start_row, start_column)
//   char_in     in         char_byte: one source byte
//   token_out   out        token_kind, value_byte, has_byte, token_last, token_row,
//                          token_column: one token item
//
// One source byte is taken per cycle while the record queue has room and no register
// write is offered. The byte's first item is written into the record queue, then loaded
// into the back end's output register and presented on token_out. A byte yields up
// to two items and token_out delivers one item per cycle while ready is high, so the
// output port sets the sustained rate when many bytes close a token and open another.
// Reset (arst_n low) clears the lexer, empties the queue and sets both position
// counters to 1. A stall on token_out fills the queue and then holds char_in off.
`default_nettype none

module assembly_source_tokenizer_unit
	import ast_pkg::*;
	#(
	parameter int ROW_BITS    = ROW_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
	) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ast_cfg_if.sink     cfg,
	ast_byte_if.sink    char_in,
	ast_token_if.source token_out
	);

	// A record holds two token items and a flag saying whether the second is used.
	localparam int REC_BITS = 2 * (ITEM_FIXED_BITS + ROW_BITS + COLUMN_BITS) + 1;

	logic                push, pop;
	logic [REC_BITS-1:0] push_data, rd_data;
	queue_status_t       queue_status;

	// The front end runs the lexer on every accepted byte. It owns the position
	// counters, which the register writes load directly.
	ast_front #(
		.ROW_BITS   (ROW_BITS),
		.COLUMN_BITS(COLUMN_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.char_in     (char_in),
		.queue_status(queue_status),
		.push        (push),
		.push_data   (push_data)
	);

	// The queue lets the front end keep taking bytes while a result waits.
	ast_queue #(
		.WIDTH(REC_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(push_data),
		.pop    (pop),
		.rd_data(rd_data),
		.status (queue_status)
	);

	// The back end holds the current record in its output register and
	// presents its items in order.
	ast_back #(
		.ROW_BITS   (ROW_BITS),
		.COLUMN_BITS(COLUMN_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_data     (rd_data),
		.queue_status(queue_status),
		.pop         (pop),
		.token_out   (token_out)
	);

endmodule

`default_nettype wire

// ===== hdl/ast_front.sv =====
// Front end of the tokenizer: takes source bytes, runs the lexer state and the
// position counters, and pushes zero to two token items per byte. Uses ast_pkg.
`default_nettype none

module ast_front
	import ast_pkg::*;
	#(
	parameter int ROW_BITS    = ROW_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
	) (
	input  wire logic clk,
	input  wire logic arst_n,
	ast_cfg_if.sink   cfg,
	ast_byte_if.sink  char_in,
	input  wire queue_status_t queue_status,
	output logic      push,
	output logic [2*(ITEM_FIXED_BITS+ROW_BITS+COLUMN_BITS):0] push_data
	);

	typedef struct packed {
		token_kind_t            kind;
		logic [7:0]             value;
		logic                   has;
		logic                   last;
		logic [ROW_BITS-1:0]    row;
		logic [COLUMN_BITS-1:0] col;
	} item_t;

	typedef struct packed {
		item_t a;
		item_t b;
		logic  two;
	} record_t;

	function automatic item_t make_item(input token_kind_t kind, input logic [7:0] value,
		input logic has, input logic last, input logic [ROW_BITS-1:0] row,
		input logic [COLUMN_BITS-1:0] col);
		item_t it;
		it.kind  = kind;
		it.value = has ? value : 8'h00;
		it.has   = has;
		it.last  = last;
		it.row   = row;
		it.col   = col;
		return it;
	endfunction

	lex_mode_t              mode_q, mode_d;
	logic [ROW_BITS-1:0]    row_q, row_d, row_inc, hold_row_q;
	logic [COLUMN_BITS-1:0] col_q, col_d, col_inc, hold_col_q;
	logic [7:0]             char_hold_q, char_d;
	logic                   hold_load;
	logic                   accept;
	logic [7:0]             b;
	logic                   zero, more;
	token_kind_t            open_kind;

	// Outcome of a byte seen between tokens
	lex_mode_t              idle_mode;
	logic [ROW_BITS-1:0]    idle_row;
	logic [COLUMN_BITS-1:0] idle_col;
	logic                   idle_hold, idle_emit;
	item_t                  idle_item;

	item_t                  item_a, item_b;
	logic                   emit_a, emit_b;
	record_t                rec;

	// A byte is held off while a register write is offered, so a write never
	// meets a byte in the same cycle.
	assign cfg.ready     = 1'b1;
	assign char_in.ready = queue_status.not_full && !cfg.valid;
	assign accept        = char_in.valid && char_in.ready;
	assign b             = char_in.char_byte;
	assign zero          = (b == CH_NUL);

	assign row_inc = (row_q == {ROW_BITS{1'b1}}) ? row_q : row_q + ROW_BITS'(1);
	assign col_inc = (col_q == {COLUMN_BITS{1'b1}}) ? col_q : col_q + COLUMN_BITS'(1);

	assign open_kind = (mode_q == LEX_IDENT) ? KIND_IDENT : KIND_INT;
	assign more = (mode_q == LEX_IDENT)
		? (is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE))
		: (is_digit(b) || (b == CH_LOWER_X) || (b == CH_LOWER_B));

	always_comb begin
		idle_mode = LEX_IDLE;
		idle_row  = row_q;
		idle_col  = col_inc;
		idle_hold = 1'b0;
		idle_emit = 1'b0;
		idle_item = make_item(KIND_EOF, b, 1'b0, 1'b1, row_q, col_q);
		if ((b == CH_SPACE) || (b == CH_TAB)) begin
			idle_mode = LEX_IDLE;
		end else if (b == CH_NEWLINE) begin
			idle_row = row_inc;
			idle_col = COLUMN_BITS'(1);
		end else if (is_alpha(b) || (b == CH_UNDERSCORE)) begin
			idle_hold = 1'b1;
			idle_emit = 1'b1;
			idle_mode = LEX_IDENT;
			idle_item = make_item(KIND_IDENT, b, 1'b1, 1'b0, row_q, col_q);
		end else if (is_digit(b)) begin
			idle_hold = 1'b1;
			idle_emit = 1'b1;
			idle_mode = LEX_NUM;
			idle_item = make_item(KIND_INT, b, 1'b1, 1'b0, row_q, col_q);
		end else if (b == CH_DQUOTE) begin
			idle_hold = 1'b1;
			idle_mode = LEX_STR;
		end else if (b == CH_APOSTROPHE) begin
			idle_hold = 1'b1;
			idle_mode = LEX_CHR;
		end else if (b == CH_COLON) begin
			idle_hold = 1'b1;
			idle_emit = 1'b1;
			idle_item = make_item(KIND_COLON, b, 1'b0, 1'b1, row_q, col_q);
		end else if (b == CH_SEMICOLON) begin
			idle_mode = LEX_COMMENT;
		end else begin
			// zero or unknown byte: end of input, column stays put
			idle_emit = 1'b1;
			idle_mode = LEX_HALT;
			idle_col  = col_q;
		end
	end

	// Next lexer state and position
	always_comb begin
		mode_d    = mode_q;
		row_d     = row_q;
		col_d     = col_q;
		hold_load = 1'b0;
		char_d    = char_hold_q;
		unique case (mode_q) inside
			LEX_HALT: begin
				mode_d = LEX_HALT;
			end
			LEX_IDENT, LEX_NUM: begin
				if (more) begin
					col_d = col_inc;
				end else begin
					mode_d    = idle_mode;
					row_d     = idle_row;
					col_d     = idle_col;
					hold_load = idle_hold;
				end
			end
			LEX_STR: begin
				if (zero) begin
					mode_d = LEX_HALT;
				end else begin
					col_d = col_inc;
					if (b == CH_DQUOTE) begin
						mode_d = LEX_IDLE;
					end else if (b == CH_BACKSLASH) begin
						mode_d = LEX_STR_ESC;
					end
				end
			end
			LEX_STR_ESC: begin
				if (zero) begin
					mode_d = LEX_HALT;
				end else begin
					mode_d = LEX_STR;
					col_d  = col_inc;
				end
			end
			LEX_CHR, LEX_CHR_ESC: begin
				if (zero) begin
					mode_d = LEX_HALT;
				end else if ((mode_q == LEX_CHR) && (b == CH_BACKSLASH)) begin
					mode_d = LEX_CHR_ESC;
					col_d  = col_inc;
				end else begin
					char_d = (mode_q == LEX_CHR) ? b : escape_value(b);
					mode_d = LEX_CHR_SKIP;
					col_d  = col_inc;
				end
			end
			LEX_CHR_SKIP: begin
				if (zero) begin
					mode_d = LEX_HALT;
				end else begin
					mode_d = LEX_IDLE;
					col_d  = col_inc;
				end
			end
			LEX_COMMENT: begin
				if ((b == CH_NEWLINE) || zero) begin
					mode_d    = idle_mode;
					row_d     = idle_row;
					col_d     = idle_col;
					hold_load = idle_hold;
				end else begin
					col_d = col_inc;
				end
			end
			default: begin
				mode_d    = idle_mode;
				row_d     = idle_row;
				col_d     = idle_col;
				hold_load = idle_hold;
			end
		endcase
	end

	// Token items caused by the byte
	always_comb begin
		emit_a = 1'b0;
		emit_b = 1'b0;
		item_a = idle_item;
		item_b = make_item(KIND_EOF, b, 1'b0, 1'b1, row_q, col_q);
		unique case (mode_q) inside
			LEX_HALT: begin
				emit_a = 1'b0;
			end
			LEX_IDENT, LEX_NUM: begin
				emit_a = 1'b1;
				if (more) begin
					item_a = make_item(open_kind, b, 1'b1, 1'b0, hold_row_q, hold_col_q);
				end else begin
					item_a = make_item(open_kind, b, 1'b0, 1'b1, hold_row_q, hold_col_q);
					emit_b = idle_emit;
					item_b = idle_item;
				end
			end
			LEX_STR: begin
				if (zero || (b == CH_DQUOTE)) begin
					emit_a = 1'b1;
					emit_b = zero;
					item_a = make_item(KIND_STR, b, 1'b0, 1'b1, hold_row_q, hold_col_q);
				end else if (b != CH_BACKSLASH) begin
					emit_a = 1'b1;
					item_a = make_item(KIND_STR, b, 1'b1, 1'b0, hold_row_q, hold_col_q);
				end
			end
			LEX_STR_ESC: begin
				if (zero) begin
					emit_a = 1'b1;
					emit_b = 1'b1;
					item_a = make_item(KIND_STR, b, 1'b0, 1'b1, hold_row_q, hold_col_q);
				end else if ((b == CH_LOWER_N) || (b == CH_LOWER_T)) begin
					emit_a = 1'b1;
					item_a = make_item(KIND_STR, escape_value(b), 1'b1, 1'b0,
						hold_row_q, hold_col_q);
				end
			end
			LEX_CHR, LEX_CHR_ESC: begin
				if (zero) begin
					emit_a = 1'b1;
					emit_b = 1'b1;
					item_a = make_item(KIND_CHR, b, 1'b0, 1'b1, hold_row_q, hold_col_q);
				end
			end
			LEX_CHR_SKIP: begin
				emit_a = 1'b1;
				emit_b = zero;
				item_a = make_item(KIND_CHR, char_hold_q, 1'b1, 1'b1, hold_row_q, hold_col_q);
			end
			LEX_COMMENT: begin
				emit_a = ((b == CH_NEWLINE) || zero) && idle_emit;
			end
			default: begin
				emit_a = idle_emit;
			end
		endcase
	end

	assign rec.a     = item_a;
	assign rec.b     = item_b;
	assign rec.two   = emit_b;
	assign push      = accept && emit_a;
	assign push_data = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= LEX_IDLE;
			row_q       <= ROW_BITS'(1);
			col_q       <= COLUMN_BITS'(1);
			hold_row_q  <= '0;
			hold_col_q  <= '0;
			char_hold_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_START_ROW) begin
				row_q <= cfg.data[ROW_BITS-1:0];
			end else if (cfg.index == REG_START_COLUMN) begin
				col_q <= cfg.data[COLUMN_BITS-1:0];
			end
		end else if (accept) begin
			mode_q      <= mode_d;
			row_q       <= row_d;
			col_q       <= col_d;
			char_hold_q <= char_d;
			if (hold_load) begin
				hold_row_q <= row_q;
				hold_col_q <= col_q;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ast_queue.sv =====
// Short queue of token records between the tokenizer's front and back ends.
// Uses ast_pkg for the depth and the status struct.
`default_nettype none

module ast_queue
	import ast_pkg::*;
	#(
	parameter int WIDTH = 1
	) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rd_data,
	output queue_status_t         status
	);

	localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]      entries_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [COUNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign status.not_empty = (count_q != '0);
	assign status.not_full  = (count_q != COUNT_BITS'(QUEUE_DEPTH));
	assign rd_data          = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + COUNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - COUNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ast_back.sv =====
// Back end of the tokenizer: takes token records from the queue and hands out
// their one or two items, one per transaction. Uses ast_pkg.
`default_nettype none

module ast_back
	import ast_pkg::*;
	#(
	parameter int ROW_BITS    = ROW_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
	) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [2*(ITEM_FIXED_BITS+ROW_BITS+COLUMN_BITS):0] rd_data,
	input  wire queue_status_t queue_status,
	output logic              pop,
	ast_token_if.source       token_out
	);

	typedef struct packed {
		token_kind_t            kind;
		logic [7:0]             value;
		logic                   has;
		logic                   last;
		logic [ROW_BITS-1:0]    row;
		logic [COLUMN_BITS-1:0] col;
	} item_t;

	typedef struct packed {
		item_t a;
		item_t b;
		logic  two;
	} record_t;

	record_t rec_q;
	logic    valid_q, phase_q;
	logic    take, finish, load;
	item_t   cur;

	assign take   = valid_q && token_out.ready;
	assign finish = take && (phase_q || !rec_q.two);
	assign load   = queue_status.not_empty && (!valid_q || finish);
	assign pop    = load;

	assign cur                    = phase_q ? rec_q.b : rec_q.a;
	assign token_out.valid        = valid_q;
	assign token_out.token_kind   = cur.kind;
	assign token_out.value_byte   = cur.value;
	assign token_out.has_byte     = cur.has;
	assign token_out.token_last   = cur.last;
	assign token_out.token_row    = cur.row;
	assign token_out.token_column = cur.col;

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= 1'b0;
		end else if (finish) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (take) begin
			phase_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ast_checker.sv =====
// Port-level checks of the tokenizer's token output, bound to the top level.
// Depends on ast_pkg and the assertion macros header.
`default_nettype none
`include "assembly_source_tokenizer_unit_defines.svh"

module ast_checker
	import ast_pkg::*;
	#(
	parameter int ROW_BITS    = ROW_BITS_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
	) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [2:0]             token_kind,
	input wire logic [7:0]             value_byte,
	input wire logic                   has_byte,
	input wire logic                   token_last,
	input wire logic [ROW_BITS-1:0]    token_row,
	input wire logic [COLUMN_BITS-1:0] token_column
	);

	logic out_take, term_kind;
	logic [ITEM_FIXED_BITS+ROW_BITS+COLUMN_BITS-1:0] out_payload;

	assign out_take    = out_valid && out_ready;
	assign term_kind   = (token_kind == KIND_COLON) || (token_kind == KIND_EOF);
	assign out_payload = {token_kind, value_byte, has_byte, token_last, token_row,
		token_column};

	`AST_ASSERT(a_valid_held, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`AST_ASSERT(a_payload_held, clk, arst_n, out_valid && !out_ready |=> $stable(out_payload))
	`AST_ASSERT(a_nothing_after_eof, clk, arst_n, out_take && (token_kind == KIND_EOF) |=> !out_valid)
	`AST_ASSERT_IMPLY(a_empty_value_zero, clk, arst_n, out_valid && !has_byte, value_byte == 8'h00)
	`AST_ASSERT_IMPLY(a_single_item_kinds, clk, arst_n, out_valid && term_kind, token_last && !has_byte)

endmodule

bind assembly_source_tokenizer_unit ast_checker #(
	.ROW_BITS   (ROW_BITS),
	.COLUMN_BITS(COLUMN_BITS)
) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (token_out.valid),
	.out_ready   (token_out.ready),
	.token_kind  (token_out.token_kind),
	.value_byte  (token_out.value_byte),
	.has_byte    (token_out.has_byte),
	.token_last  (token_out.token_last),
	.token_row   (token_out.token_row),
	.token_column(token_out.token_column)
);

`default_nettype wire
